>>> hdl/rsef_pkg.sv
// Shared types and codes of the row select equality filter.
`timescale 1ns / 1ps
`default_nettype none

package rsef_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_KEY   = 2'd1,
    OP_ELEM  = 2'd2,
    OP_DRAIN = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_KEY_OVERFLOW = 3'd1,
    ST_ROW_OVERFLOW = 3'd2,
    ST_ROW_PENDING  = 3'd3,
    ST_EMPTY_DRAIN  = 3'd4,
    ST_TABLE_ENDED  = 3'd5
  } status_e;

  // register index on the config port: paddr[2] selects the word
  localparam logic REG_KEY_COLUMN = 1'b0;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned KEY_COL_W = 7;

  // classified input word
  typedef struct packed {
    logic              is_clear;
    logic              is_key;
    logic              is_elem;
    logic              is_drain;
    logic [CHAR_W-1:0] ch;
    logic              eoc;  // end_of_cell or end_of_row
    logic              eor;
  } in_word_t;

  // result word
  typedef struct packed {
    logic              valid;
    logic [CHAR_W-1:0] ch;
    logic              eoc;
    logic              eor;
    logic              pending;
    status_e           status;
  } out_word_t;

endpackage

`default_nettype wire

>>> hdl/rsef_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module rsef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/rsef_fifo.sv
// Small register FIFO used for the input and result queues.
`timescale 1ns / 1ps
`default_nettype none

module rsef_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rsef_front.sv
// Front end: takes input words, decodes the opcode and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module rsef_front
  import rsef_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [CHAR_W-1:0] char_value_i,
  input  wire logic              end_of_cell_i,
  input  wire logic              end_of_row_i,
  input  wire logic              pop_i,
  output in_word_t               word_o,
  output logic                   empty_o
);

  in_word_t             cls;
  logic [$bits(in_word_t)-1:0] q_rdata;

  always_comb begin
    cls          = '0;
    cls.ch       = char_value_i;
    cls.eor      = end_of_row_i;
    cls.eoc      = end_of_cell_i || end_of_row_i;  // end of row also ends the cell
    unique case (opcode_e'(opcode_i))
      OP_CLEAR: cls.is_clear = 1'b1;
      OP_KEY:   cls.is_key   = 1'b1;
      OP_ELEM:  cls.is_elem  = 1'b1;
      OP_DRAIN: cls.is_drain = 1'b1;
      default:  cls.is_drain = 1'b1;
    endcase
  end

  rsef_fifo #(
    .WIDTH ($bits(in_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls),
    .full_o  (full),
    .pop_i   (pop_i),
    .rdata_o (q_rdata),
    .empty_o (empty_o)
  );

  assign word_o = in_word_t'(q_rdata);

endmodule

`default_nettype wire

>>> hdl/rsef_back.sv
// Back end: key and row buffers, cell compare, row select and drain, one word per cycle unless held.
`timescale 1ns / 1ps
`default_nettype none

module rsef_back
  import rsef_pkg::*;
#(
  parameter int unsigned KEY_BYTES = 64,
  parameter int unsigned ROW_ELEMS = 1024,
  parameter int unsigned MAX_COLS  = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [KEY_COL_W-1:0] key_column_i,
  input  in_word_t                  in_word_i,
  input  wire logic                 in_empty_i,
  output logic                      in_pop_o,
  input  wire logic                 out_full_i,
  output logic                      out_push_o,
  output out_word_t                 out_word_o
);

  localparam int unsigned KLW  = $clog2(KEY_BYTES + 1);
  localparam int unsigned CIW  = $clog2(KEY_BYTES + 2);
  localparam int unsigned KAW  = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int unsigned RFW  = $clog2(ROW_ELEMS + 1);
  localparam int unsigned RAW  = (ROW_ELEMS > 1) ? $clog2(ROW_ELEMS) : 1;
  localparam int unsigned COLW = $clog2(MAX_COLS + 1);
  localparam int unsigned CMPW = (COLW > KEY_COL_W) ? COLW : KEY_COL_W;
  localparam int unsigned RW   = CHAR_W + 1;

  logic [KLW-1:0]  kl_q, kl_d;
  logic            kov_q, kov_d;
  logic [RFW-1:0]  fill_q, fill_d;
  logic [COLW-1:0] col_q, col_d;
  logic [CIW-1:0]  cci_q, cci_d;
  logic            eq_q, eq_d;
  logic            matched_q, matched_d;
  logic            seen_q, seen_d;
  logic            stopped_q, stopped_d;
  logic            ovf_q, ovf_d;
  logic            ended_q, ended_d;
  logic            pend_q, pend_d;
  logic [RFW-1:0]  dp_q, dp_d;

  logic              key_we;
  logic [KAW-1:0]    key_waddr;
  logic [KAW-1:0]    key_raddr;
  logic [CHAR_W-1:0] key_ram_rdata;
  logic [CHAR_W-1:0] key_byp_q;
  logic              key_byp_vld_q;
  logic [CHAR_W-1:0] key_byte;

  logic          row_we;
  logic [RAW-1:0] row_waddr;
  logic [RW-1:0]  row_wdata;
  logic [RAW-1:0] row_raddr;
  logic [RW-1:0]  row_ram_rdata;
  logic [RW-1:0]  row_byp_q;
  logic           row_byp_vld_q;
  logic [RW-1:0]  row_elem;

  logic      exec;
  logic      is_key_col;
  logic      empty_cell;
  logic      hit;
  out_word_t res;

  assign exec       = !in_empty_i && !out_full_i;
  assign in_pop_o   = exec;
  assign out_push_o = exec;
  assign out_word_o = res;

  assign is_key_col = (CMPW'(col_q) == CMPW'(key_column_i));
  assign empty_cell = in_word_i.eoc && (in_word_i.ch == '0) && (cci_q == '0);

  // The RAMs are read every cycle at the next state's address, so the data for the
  // current index is ready when the next word executes. A write to the address being
  // read in the same cycle is forwarded.
  assign key_byte = key_byp_vld_q ? key_byp_q : key_ram_rdata;
  assign row_elem = row_byp_vld_q ? row_byp_q : row_ram_rdata;
  assign key_waddr = kl_q[KAW-1:0];
  assign key_raddr = cci_d[KAW-1:0];
  assign row_waddr = fill_q[RAW-1:0];
  assign row_wdata = {in_word_i.eoc, in_word_i.ch};
  assign row_raddr = dp_d[RAW-1:0];

  always_comb begin
    kl_d      = kl_q;
    kov_d     = kov_q;
    fill_d    = fill_q;
    col_d     = col_q;
    cci_d     = cci_q;
    eq_d      = eq_q;
    matched_d = matched_q;
    seen_d    = seen_q;
    stopped_d = stopped_q;
    ovf_d     = ovf_q;
    ended_d   = ended_q;
    pend_d    = pend_q;
    dp_d      = dp_q;
    key_we    = 1'b0;
    row_we    = 1'b0;
    hit       = 1'b0;
    res       = '0;
    res.status = ST_OK;

    if (exec) begin
      priority if (in_word_i.is_clear) begin
        kl_d      = '0;
        kov_d     = 1'b0;
        fill_d    = '0;
        col_d     = '0;
        cci_d     = '0;
        eq_d      = 1'b1;
        matched_d = 1'b0;
        seen_d    = 1'b0;
        stopped_d = 1'b0;
        ovf_d     = 1'b0;
        ended_d   = 1'b0;
        pend_d    = 1'b0;
        dp_d      = '0;
      end else if (in_word_i.is_key) begin
        if (kl_q < KLW'(KEY_BYTES)) begin
          key_we = 1'b1;
          kl_d   = kl_q + KLW'(1);
        end else begin
          kov_d      = 1'b1;
          res.status = ST_KEY_OVERFLOW;
        end
      end else if (in_word_i.is_elem) begin
        priority if (ended_q) begin
          res.status = ST_TABLE_ENDED;
        end else if (pend_q) begin
          res.status = ST_ROW_PENDING;
        end else if (col_q == '0 && empty_cell) begin
          // empty first cell: end of table, the row is dropped
          ended_d   = 1'b1;
          fill_d    = '0;
          col_d     = '0;
          cci_d     = '0;
          eq_d      = 1'b1;
          matched_d = 1'b0;
          seen_d    = 1'b0;
          stopped_d = 1'b0;
          ovf_d     = 1'b0;
        end else begin
          if (col_q >= COLW'(MAX_COLS)) begin
            ovf_d      = 1'b1;
            res.status = ST_ROW_OVERFLOW;
          end else begin
            if (!empty_cell) begin
              if (is_key_col && !(CIW'(cci_q) < CIW'(kl_q) && cci_q < CIW'(KEY_BYTES) &&
                                  key_byte == in_word_i.ch)) begin
                eq_d = 1'b0;
              end
              if (!stopped_q) begin
                if (fill_q < RFW'(ROW_ELEMS)) begin
                  row_we = 1'b1;
                  fill_d = fill_q + RFW'(1);
                end else begin
                  ovf_d      = 1'b1;
                  res.status = ST_ROW_OVERFLOW;
                end
              end
              if (cci_q <= CIW'(KEY_BYTES)) begin
                cci_d = cci_q + CIW'(1);
              end
            end else begin
              stopped_d = 1'b1;  // copy ends at the first empty cell
            end
            if (in_word_i.eoc) begin
              if (is_key_col) begin
                seen_d    = 1'b1;
                matched_d = eq_d && (cci_d == CIW'(kl_q)) && !kov_q;
              end
              cci_d = '0;
              eq_d  = 1'b1;
              col_d = col_q + COLW'(1);
            end
          end
          if (in_word_i.eor) begin
            hit = seen_d ? matched_d : (kl_q == '0 && !kov_q);
            if (hit && !ovf_d && fill_d != '0) begin
              pend_d = 1'b1;
              dp_d   = '0;
            end else begin
              fill_d = '0;
            end
            col_d     = '0;
            cci_d     = '0;
            eq_d      = 1'b1;
            matched_d = 1'b0;
            seen_d    = 1'b0;
            stopped_d = 1'b0;
            ovf_d     = 1'b0;
          end
        end
      end else begin
        if (pend_q && dp_q < fill_q && dp_q < RFW'(ROW_ELEMS)) begin
          res.valid = 1'b1;
          res.ch    = row_elem[CHAR_W-1:0];
          res.eoc   = row_elem[CHAR_W];
          res.eor   = ((dp_q + RFW'(1)) == fill_q);
          dp_d      = dp_q + RFW'(1);
          if (dp_d >= fill_q) begin
            pend_d = 1'b0;
            fill_d = '0;
            dp_d   = '0;
          end
        end else begin
          pend_d     = 1'b0;
          res.status = ST_EMPTY_DRAIN;
        end
      end
    end
    res.pending = pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kl_q          <= '0;
      kov_q         <= 1'b0;
      fill_q        <= '0;
      col_q         <= '0;
      cci_q         <= '0;
      eq_q          <= 1'b1;
      matched_q     <= 1'b0;
      seen_q        <= 1'b0;
      stopped_q     <= 1'b0;
      ovf_q         <= 1'b0;
      ended_q       <= 1'b0;
      pend_q        <= 1'b0;
      dp_q          <= '0;
      key_byp_vld_q <= 1'b0;
      row_byp_vld_q <= 1'b0;
    end else begin
      kl_q          <= kl_d;
      kov_q         <= kov_d;
      fill_q        <= fill_d;
      col_q         <= col_d;
      cci_q         <= cci_d;
      eq_q          <= eq_d;
      matched_q     <= matched_d;
      seen_q        <= seen_d;
      stopped_q     <= stopped_d;
      ovf_q         <= ovf_d;
      ended_q       <= ended_d;
      pend_q        <= pend_d;
      dp_q          <= dp_d;
      key_byp_vld_q <= key_we && (key_waddr == key_raddr);
      row_byp_vld_q <= row_we && (row_waddr == row_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    key_byp_q <= in_word_i.ch;
    row_byp_q <= row_wdata;
  end

  rsef_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (KEY_BYTES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (in_word_i.ch),
    .raddr_i (key_raddr),
    .rdata_o (key_ram_rdata)
  );

  rsef_ram #(
    .WIDTH (RW),
    .DEPTH (ROW_ELEMS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_ram_rdata)
  );

endmodule

`default_nettype wire

>>> hdl/row_select_equality_filter.sv
// Top level of the row select equality filter: queues, back end and config register.
// Words enter on push/full: opcode 0 clears the key and restarts, 1 appends a key
// byte, 2 is a table element (byte, end of cell, end of row), 3 drains one element
// of the selected row. Every word gives exactly one result word, taken on
// empty/pop, in input order.
// The back end executes one word per cycle while the result queue has room, so a word
// can then be pushed every cycle; a word's result reaches the result ports once the
// back end takes it from the input queue and writes the result queue.
// Throughput is set by the single back-end step that reads the key RAM for the
// compare and writes or reads the row RAM.
// When pop stays low the two-entry result queue fills, the back end holds and the
// input queue then raises full; nothing is lost.
// Reset empties both queues, clears key length, row state, table end and the
// pending row, and sets key_column to 0. The key and row RAMs are not cleared;
// only entries written since are ever read. key_column is written over the APB port
// at byte address 0; the user writes it only while idle, the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module row_select_equality_filter
  import rsef_pkg::*;
#(
  parameter int unsigned KEY_BYTES = 64,
  parameter int unsigned ROW_ELEMS = 1024,
  parameter int unsigned MAX_COLS  = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [CHAR_W-1:0] char_value_i,
  input  wire logic              end_of_cell_i,
  input  wire logic              end_of_row_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   out_valid_o,
  output logic      [CHAR_W-1:0] out_char_o,
  output logic                   out_end_of_cell_o,
  output logic                   out_end_of_row_o,
  output logic                   row_pending_o,
  output logic      [2:0]        status_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  logic [KEY_COL_W-1:0] key_column_q, key_column_d;
  logic                 cfg_wr;

  in_word_t  in_word;
  logic      in_empty;
  logic      in_pop;
  out_word_t res_word;
  logic      res_push;
  logic      res_full;
  logic [$bits(out_word_t)-1:0] res_rdata;
  out_word_t res_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_KEY_COLUMN);
  assign prdata = (paddr[2] == REG_KEY_COLUMN) ? {{(32 - KEY_COL_W){1'b0}}, key_column_q}
                                               : '0;

  always_comb begin
    key_column_d = key_column_q;
    if (cfg_wr) begin
      key_column_d = pwdata[KEY_COL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_column_q <= '0;
    end else begin
      key_column_q <= key_column_d;
    end
  end

  rsef_front #(
    .QUEUE_DEPTH (2)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .char_value_i  (char_value_i),
    .end_of_cell_i (end_of_cell_i),
    .end_of_row_i  (end_of_row_i),
    .pop_i         (in_pop),
    .word_o        (in_word),
    .empty_o       (in_empty)
  );

  rsef_back #(
    .KEY_BYTES (KEY_BYTES),
    .ROW_ELEMS (ROW_ELEMS),
    .MAX_COLS  (MAX_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_column_i (key_column_q),
    .in_word_i    (in_word),
    .in_empty_i   (in_empty),
    .in_pop_o     (in_pop),
    .out_full_i   (res_full),
    .out_push_o   (res_push),
    .out_word_o   (res_word)
  );

  rsef_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_word),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign res_head          = out_word_t'(res_rdata);
  assign out_valid_o       = res_head.valid;
  assign out_char_o        = res_head.ch;
  assign out_end_of_cell_o = res_head.eoc;
  assign out_end_of_row_o  = res_head.eor;
  assign row_pending_o     = res_head.pending;
  assign status_o          = res_head.status;

endmodule

`default_nettype wire
